// ===== hw/rtl/swmm_pkg.sv =====
package swmm_pkg;

    // width of the window length register
    localparam int LEN_W = 9;

    // default sizes handed to the top level parameters
    localparam int WINDOW_MAX_DEF  = 256;
    localparam int SAMPLE_BITS_DEF = 32;

    // one flag per deque, passed between neighboring cells
    typedef struct packed {
        logic min;
        logic max;
    } link_t;

    // per-transaction control broadcast to every cell
    typedef struct packed {
        logic restart;
        logic min_shift;
        logic max_shift;
    } ctl_t;

endpackage

// ===== hw/rtl/swmm_cell.sv =====
module swmm_cell
    import swmm_pkg::*;
#(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int AGE_W       = 8,
    parameter int CNT_W       = 9
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  ctl_t                          ctl,
    input  logic [CNT_W-1:0]              win_len,
    input  logic signed [SAMPLE_BITS-1:0] right_min_val,
    input  logic [AGE_W-1:0]              right_min_age,
    input  logic                          right_min_valid,
    input  logic signed [SAMPLE_BITS-1:0] right_max_val,
    input  logic [AGE_W-1:0]              right_max_age,
    input  logic                          right_max_valid,
    input  link_t                         sel_here,
    input  link_t                         sel_left,
    input  link_t                         hit_left,
    output logic signed [SAMPLE_BITS-1:0] min_val,
    output logic [AGE_W-1:0]              min_age,
    output logic                          min_valid,
    output logic signed [SAMPLE_BITS-1:0] max_val,
    output logic [AGE_W-1:0]              max_age,
    output logic                          max_valid,
    output link_t                         keep,
    output link_t                         hit,
    output logic [2*SAMPLE_BITS-1:0]      leaf
);

    localparam logic [AGE_W-1:0] AGE_LAST = AGE_W'(WINDOW_MAX - 1);

    logic signed [SAMPLE_BITS-1:0] min_val_reg, min_val_next;
    logic [AGE_W-1:0]              min_age_reg, min_age_next;
    logic                          min_valid_reg, min_valid_next;
    logic signed [SAMPLE_BITS-1:0] max_val_reg, max_val_next;
    logic [AGE_W-1:0]              max_age_reg, max_age_next;
    logic                          max_valid_reg, max_valid_next;
    logic signed [SAMPLE_BITS-1:0] min_src_val, max_src_val;
    logic [AGE_W-1:0]              min_src_age, max_src_age;
    logic                          min_src_valid, max_src_valid;
    link_t                         first;

    // an entry survives the new sample if it still beats it and is not aging out
    assign keep.min = min_valid_reg && !ctl.restart && (min_val_reg < sample)
                      && (min_age_reg != AGE_LAST);
    assign keep.max = max_valid_reg && !ctl.restart && (max_val_reg > sample)
                      && (max_age_reg != AGE_LAST);

    // source entry: own when the deque holds still, right neighbor when it shifts
    assign min_src_val   = ctl.min_shift ? right_min_val : min_val_reg;
    assign min_src_age   = ctl.min_shift ? right_min_age : min_age_reg;
    assign min_src_valid = ctl.min_shift ? right_min_valid : min_valid_reg;
    assign max_src_val   = ctl.max_shift ? right_max_val : max_val_reg;
    assign max_src_age   = ctl.max_shift ? right_max_age : max_age_reg;
    assign max_src_valid = ctl.max_shift ? right_max_valid : max_valid_reg;

    // min deque next entry: survivor, new sample at the tail, or empty
    always_comb
    begin
        min_val_next   = min_src_val;
        min_age_next   = min_src_age + AGE_W'(1);
        min_valid_next = min_src_valid;
        if (!sel_here.min)
        begin
            min_val_next   = sample;
            min_age_next   = '0;
            min_valid_next = sel_left.min;
        end
    end

    // max deque next entry
    always_comb
    begin
        max_val_next   = max_src_val;
        max_age_next   = max_src_age + AGE_W'(1);
        max_valid_next = max_src_valid;
        if (!sel_here.max)
        begin
            max_val_next   = sample;
            max_age_next   = '0;
            max_valid_next = sel_left.max;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_valid_reg <= 1'b0;
            max_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            min_valid_reg <= min_valid_next;
            max_valid_reg <= max_valid_next;
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            min_val_reg <= min_val_next;
            min_age_reg <= min_age_next;
            max_val_reg <= max_val_next;
            max_age_reg <= max_age_next;
        end
    end

    // inside the window, and the oldest such entry of its deque
    assign hit.min   = min_valid_reg && (CNT_W'(min_age_reg) < win_len);
    assign hit.max   = max_valid_reg && (CNT_W'(max_age_reg) < win_len);
    assign first.min = hit.min && !hit_left.min;
    assign first.max = hit.max && !hit_left.max;

    assign leaf = {first.max ? max_val_reg : {SAMPLE_BITS{1'b0}},
                   first.min ? min_val_reg : {SAMPLE_BITS{1'b0}}};

    assign min_val   = min_val_reg;
    assign min_age   = min_age_reg;
    assign min_valid = min_valid_reg;
    assign max_val   = max_val_reg;
    assign max_age   = max_age_reg;
    assign max_valid = max_valid_reg;

endmodule

// ===== hw/rtl/swmm_or_tree.sv =====
module swmm_or_tree
    import swmm_pkg::*;
#(
    parameter int N_LEAF = WINDOW_MAX_DEF,
    parameter int W      = 2 * SAMPLE_BITS_DEF
)
(
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] leaf [N_LEAF],
    output logic [W-1:0] root
);

    localparam int LEVELS = (N_LEAF > 1) ? $clog2(N_LEAF) : 0;
    localparam int NP     = 2 ** LEVELS;

    generate
        if (LEVELS == 0)
        begin : g_single
            assign root = leaf[0];
        end
        else
        begin : g_tree
            logic [W-1:0] node_reg [NP-1];
            logic [W-1:0] node_in  [2*NP-1];

            // heap layout: internal nodes first, then the leaves
            for (genvar k = 0; k < NP - 1; k++)
            begin : g_node
                assign node_in[k] = node_reg[k];

                // one registered level per stage
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        node_reg[k] <= node_in[2*k+1] | node_in[2*k+2];
                    end
                end
            end

            for (genvar i = 0; i < NP; i++)
            begin : g_leaf
                if (i < N_LEAF)
                begin : g_used
                    assign node_in[NP-1+i] = leaf[i];
                end
                else
                begin : g_pad
                    assign node_in[NP-1+i] = '0;
                end
            end

            assign root = node_reg[0];
        end
    endgenerate

endmodule

// ===== hw/rtl/sliding_window_min_max.sv =====
// channel  | direction | handshake             | content
// s_*      | in        | s_tvalid / s_tready   | tdata: sample; tuser: restart
// m_*      | out       | m_tvalid / m_tready   | tdata: window_min, window_max
// cfg_*    | in        | cfg_valid / cfg_ready | window_len (9 bits)
//
// one sample per cycle while the output is not stalled; a result leaves through the
// registered reduction tree over the cell row (8 levels at 256)
// each sample updates a row of WINDOW_MAX cells holding a min and a max deque
// reset sets window_len to 1 and clears the fill count, the deque valid bits and the result flags
// a stalled output holds the whole pipeline and s_tready drops in the same cycle
module sliding_window_min_max
    import swmm_pkg::*;
#(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,  // sample
    input  logic [0:0]                             s_tuser,  // restart
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,  // window_min, window_max
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [LEN_W-1:0]                       cfg_data
);

    localparam int OUT_W  = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int AGE_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W  = ($clog2(WINDOW_MAX+1) > LEN_W) ? $clog2(WINDOW_MAX+1) : LEN_W;
    localparam int LEVELS = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 0;
    localparam logic [AGE_W-1:0] AGE_LAST = AGE_W'(WINDOW_MAX - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(WINDOW_MAX);

    logic [LEN_W-1:0]              window_len_reg;
    logic [CNT_W-1:0]              fill_count_reg, fill_count_next, fill_base;
    logic [CNT_W-1:0]              len_ext, eff_len;
    logic [LEVELS:0]               tag_reg;
    logic                          en, accept, has_result, restart;
    logic signed [SAMPLE_BITS-1:0] sample;
    ctl_t                          ctl;

    logic signed [SAMPLE_BITS-1:0] min_val   [WINDOW_MAX+1];
    logic [AGE_W-1:0]              min_age   [WINDOW_MAX+1];
    logic                          min_valid [WINDOW_MAX+1];
    logic signed [SAMPLE_BITS-1:0] max_val   [WINDOW_MAX+1];
    logic [AGE_W-1:0]              max_age   [WINDOW_MAX+1];
    logic                          max_valid [WINDOW_MAX+1];
    link_t                         keep      [WINDOW_MAX+1];
    link_t                         hit       [WINDOW_MAX];
    link_t                         sel_here  [WINDOW_MAX];
    link_t                         sel_left  [WINDOW_MAX];
    link_t                         hit_left  [WINDOW_MAX];
    logic [2*SAMPLE_BITS-1:0]      leaf      [WINDOW_MAX];
    logic [2*SAMPLE_BITS-1:0]      root;

    // handshake: the pipeline moves unless a result waits at the output
    assign en        = !tag_reg[LEVELS] || m_tready;
    assign s_tready  = en;
    assign accept    = s_tvalid && en;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = tag_reg[LEVELS];
    assign m_tdata   = OUT_W'(root);

    assign sample  = s_tdata[SAMPLE_BITS-1:0];
    assign restart = s_tuser[0];

    // window length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= LEN_W'(1);
        end
        else if (cfg_valid)
        begin
            window_len_reg <= cfg_data;
        end
    end

    // length clamped to 1 .. WINDOW_MAX
    always_comb
    begin
        len_ext = CNT_W'(window_len_reg);
        eff_len = len_ext;
        if (len_ext == '0)
        begin
            eff_len = CNT_W'(1);
        end
        else if (len_ext > CNT_MAX)
        begin
            eff_len = CNT_MAX;
        end
    end

    // fill count of the current sequence, saturating
    assign fill_base       = restart ? '0 : fill_count_reg;
    assign fill_count_next = (fill_base < CNT_MAX) ? fill_base + CNT_W'(1) : fill_base;
    assign has_result      = fill_count_next >= eff_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
        end
        else if (accept)
        begin
            fill_count_reg <= fill_count_next;
        end
    end

    // result flags following the tree levels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (en)
        begin
            tag_reg[0] <= accept && has_result;
            for (int k = 1; k <= LEVELS; k++)
            begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    // deque heads age out and pull the row one cell toward the head
    assign ctl.restart   = restart;
    assign ctl.min_shift = min_valid[0] && (min_age[0] == AGE_LAST) && !restart;
    assign ctl.max_shift = max_valid[0] && (max_age[0] == AGE_LAST) && !restart;

    // empty neighbor past the tail of the row
    assign min_val[WINDOW_MAX]   = '0;
    assign min_age[WINDOW_MAX]   = '0;
    assign min_valid[WINDOW_MAX] = 1'b0;
    assign max_val[WINDOW_MAX]   = '0;
    assign max_age[WINDOW_MAX]   = '0;
    assign max_valid[WINDOW_MAX] = 1'b0;
    assign keep[WINDOW_MAX]      = '0;

    // row of cells
    generate
        for (genvar i = 0; i < WINDOW_MAX; i++)
        begin : g_cell
            assign sel_here[i].min = ctl.min_shift ? keep[i+1].min : keep[i].min;
            assign sel_here[i].max = ctl.max_shift ? keep[i+1].max : keep[i].max;

            if (i == 0)
            begin : g_head
                assign sel_left[i] = '1;
                assign hit_left[i] = '0;
            end
            else
            begin : g_body
                assign sel_left[i] = sel_here[i-1];
                assign hit_left[i] = hit[i-1];
            end

            swmm_cell #(
                .WINDOW_MAX  (WINDOW_MAX),
                .SAMPLE_BITS (SAMPLE_BITS),
                .AGE_W       (AGE_W),
                .CNT_W       (CNT_W)
            ) u_cell (
                .clk             (clk),
                .rst_n           (rst_n),
                .en              (accept),
                .sample          (sample),
                .ctl             (ctl),
                .win_len         (eff_len),
                .right_min_val   (min_val[i+1]),
                .right_min_age   (min_age[i+1]),
                .right_min_valid (min_valid[i+1]),
                .right_max_val   (max_val[i+1]),
                .right_max_age   (max_age[i+1]),
                .right_max_valid (max_valid[i+1]),
                .sel_here        (sel_here[i]),
                .sel_left        (sel_left[i]),
                .hit_left        (hit_left[i]),
                .min_val         (min_val[i]),
                .min_age         (min_age[i]),
                .min_valid       (min_valid[i]),
                .max_val         (max_val[i]),
                .max_age         (max_age[i]),
                .max_valid       (max_valid[i]),
                .keep            (keep[i]),
                .hit             (hit[i]),
                .leaf            (leaf[i])
            );
        end
    endgenerate

    // registered reduction of the selected entries
    swmm_or_tree #(
        .N_LEAF (WINDOW_MAX),
        .W      (2 * SAMPLE_BITS)
    ) u_tree (
        .clk  (clk),
        .en   (en),
        .leaf (leaf),
        .root (root)
    );

endmodule

// ===== verif/sliding_window_min_max_test.sv =====
module sliding_window_min_max_test
    import swmm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_MAX     = WINDOW_MAX_DEF;
    localparam int SW          = SAMPLE_BITS_DEF;
    localparam int IN_W        = ((SW + 7) / 8) * 8;
    localparam int OUT_W       = ((2 * SW + 7) / 8) * 8;
    // drain wait covering the cell row and the reduction tree levels, with margin for stalls
    localparam int DRAIN_WAIT  = 24;
    localparam int STALL_LIMIT = 5000;
    localparam int IDLE_PCT    = 15;

    typedef struct {
        logic signed [SW-1:0] sample;
        logic                 restart;
    } sample_item_t;

    typedef struct {
        logic signed [SW-1:0] lo;
        logic signed [SW-1:0] hi;
    } extrema_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;    // sample
    logic [0:0]        s_tuser = '0;    // restart
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;         // window_min, window_max
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [LEN_W-1:0]  cfg_data = '0;

    // stimulus and expectation stores
    sample_item_t sample_queue[$];
    extrema_t     pending_extrema[$];

    // predictor state
    logic signed [SW-1:0] window_store [WIN_MAX];
    int                   write_slot;
    int                   fill_count;
    logic [LEN_W-1:0]     win_len;

    // handshake flags sampled at the rising edge
    logic sample_taken = 1'b0;
    logic cfg_taken = 1'b0;
    logic quiet = 1'b0;

    logic signed [SW-1:0] ramp_value = '0;
    logic                 ramp_down = 1'b0;

    int error_count = 0;
    int samples_sent = 0;
    int restarts_sent = 0;
    int results_checked = 0;
    int len_writes = 0;
    int stall_cycles = 0;

    sliding_window_min_max dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    always #4 clk = ~clk;

    function automatic int clamp_len(logic [LEN_W-1:0] v);
        if (v == 0)
        begin
            return 1;
        end
        if (v > WIN_MAX)
        begin
            return WIN_MAX;
        end
        return int'(v);
    endfunction

    // store one sample and queue the min/max of the window it closes, if any
    task automatic track_sample(sample_item_t item);
        int                   span;
        int                   slot;
        logic signed [SW-1:0] v;
        extrema_t             res;
        span = clamp_len(win_len);
        if (item.restart)
        begin
            fill_count = 0;
        end
        window_store[write_slot] = item.sample;
        write_slot = (write_slot + 1) % WIN_MAX;
        if (fill_count < WIN_MAX)
        begin
            fill_count++;
        end
        if (fill_count >= span)
        begin
            for (int i = 0; i < span; i++)
            begin
                slot = (write_slot + 2 * WIN_MAX - 1 - i) % WIN_MAX;
                v = window_store[slot];
                if (i == 0 || v < res.lo)
                begin
                    res.lo = v;
                end
                if (i == 0 || v > res.hi)
                begin
                    res.hi = v;
                end
            end
            pending_extrema = {pending_extrema, res};
        end
    endtask

    task automatic report_mismatch(input string what, input logic signed [SW-1:0] got,
                                   input logic signed [SW-1:0] want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // monitor, predictor and watchdog
    always @(posedge clk)
    begin
        sample_item_t item;
        extrema_t     want;
        logic         result_taken;
        sample_taken = rst_n && s_tvalid && s_tready;
        cfg_taken = rst_n && cfg_valid && cfg_ready;
        result_taken = rst_n && m_tvalid && m_tready;

        // config transaction
        if (cfg_taken)
        begin
            win_len = cfg_data;
        end

        // input transaction
        if (sample_taken)
        begin
            item = sample_queue[0];
            sample_queue.delete(0);
            track_sample(item);
        end

        // output transaction
        if (result_taken)
        begin
            results_checked++;
            if (pending_extrema.size() == 0)
            begin
                report_mismatch("result with nothing pending (min)", m_tdata[SW-1:0], '0);
            end
            else
            begin
                want = pending_extrema[0];
                pending_extrema.delete(0);
                if (m_tdata[SW-1:0] !== want.lo)
                begin
                    report_mismatch("window_min", m_tdata[SW-1:0], want.lo);
                end
                if (m_tdata[2*SW-1:SW] !== want.hi)
                begin
                    report_mismatch("window_max", m_tdata[2*SW-1:SW], want.hi);
                end
            end
        end

        // watchdog on cycles with no transaction at all
        if (sample_taken || cfg_taken || result_taken)
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending_extrema.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // driver for the sample stream and the result ready
    always @(negedge clk)
    begin
        if (!s_tvalid || sample_taken)
        begin
            if (sample_queue.size() > 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                s_tvalid <= 1'b1;
                s_tdata <= IN_W'(sample_queue[0].sample);
                s_tuser <= sample_queue[0].restart;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= quiet || $urandom_range(0, 99) >= IDLE_PCT;
    end

    task automatic push_item(input logic signed [SW-1:0] sample, input logic restart);
        sample_item_t item;
        item.sample = sample;
        item.restart = restart;
        sample_queue = {sample_queue, item};
        samples_sent++;
        if (restart)
        begin
            restarts_sent++;
        end
    endtask

    // wait until every sample is taken and every result seen, then let the pipe drain
    task automatic drain();
        while (sample_queue.size() > 0 || pending_extrema.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_len(input logic [LEN_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
        begin
            @(negedge clk);
        end
        while (!cfg_taken);
        cfg_valid <= 1'b0;
        len_writes++;
    endtask

    // random sample: full range, small values with ties, extremes, or monotonic ramps
    function automatic logic signed [SW-1:0] next_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 3)
        begin
            return $urandom;
        end
        if (pick <= 5)
        begin
            return $signed($urandom_range(0, 8)) - 4;
        end
        if (pick == 6)
        begin
            return $urandom_range(0, 1) ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end
        if ($urandom_range(0, 31) == 0)
        begin
            ramp_down = ~ramp_down;
        end
        if (ramp_down)
        begin
            ramp_value = ramp_value - $urandom_range(0, 1000);
        end
        else
        begin
            ramp_value = ramp_value + $urandom_range(0, 1000);
        end
        return ramp_value;
    endfunction

    task automatic random_phase(input logic [LEN_W-1:0] len_value, input logic calm);
        int span;
        int restart_permille;
        write_len(len_value);
        quiet = calm;
        span = clamp_len(len_value);
        restart_permille = (span <= 33) ? 30 : 3;
        // half the phases continue the running sequence under the new length
        push_item(next_sample(), 1'($urandom_range(0, 1)));
        for (int i = 1; i < span + 110; i++)
        begin
            push_item(next_sample(), $urandom_range(0, 999) < restart_permille);
        end
    endtask

    // stimulus and end of run
    initial
    begin
        logic [LEN_W-1:0] phase_len [11];
        logic             phase_calm [11];
        phase_len = '{2, 0, 256, 7, 511, 1, 33, 130, 4, 17, 3};
        phase_calm = '{0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0};

        write_slot = 0;
        fill_count = 0;
        win_len = LEN_W'(1);
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // window of one from reset: field extremes and bit patterns
        push_item(0, 1'b0);
        push_item({1'b1, {(SW-1){1'b0}}}, 1'b0);
        push_item({1'b0, {(SW-1){1'b1}}}, 1'b0);
        push_item(-1, 1'b0);
        push_item(1, 1'b0);
        push_item(32'h5555_5555, 1'b1);
        push_item(32'haaaa_aaaa, 1'b0);

        // window of three: partial fill, restart before full, back-to-back restarts, ties
        write_len(LEN_W'(3));
        push_item(5, 1'b1);
        push_item(-7, 1'b0);
        push_item(9, 1'b1);
        push_item({1'b0, {(SW-1){1'b1}}}, 1'b0);
        push_item({1'b1, {(SW-1){1'b0}}}, 1'b0);
        push_item(0, 1'b0);
        push_item(4, 1'b1);
        push_item(4, 1'b1);
        push_item(4, 1'b0);
        push_item(-1, 1'b0);
        push_item({1'b1, {(SW-1){1'b0}}}, 1'b0);
        push_item({1'b0, {(SW-1){1'b1}}}, 1'b0);

        // random phases over a range of window lengths, zero and over-range included
        for (int p = 0; p < 11; p++)
        begin
            random_phase(phase_len[p], phase_calm[p]);
        end

        quiet = 1'b0;
        drain();
        $display("covered %0d samples (%0d restarts) across %0d window length settings",
                 samples_sent, restarts_sent, len_writes + 1);
        $display("checked %0d min/max results, %0d mismatches", results_checked, error_count);
        if (error_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/swmm_pkg.sv
hw/rtl/swmm_cell.sv
hw/rtl/swmm_or_tree.sv
hw/rtl/sliding_window_min_max.sv
verif/sliding_window_min_max_test.sv
